>>> sv/qrp_pkg.sv
// Package for the quaternion to roll/pitch unit: widths, angle constants,
// CORDIC arctangent table and the sideband struct. No dependencies.
`default_nettype none

package qrp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    localparam int PROD_W = 32;   // 16x16 signed product
    localparam int TERM_W = 36;   // sine/cosine terms in 2^-30 units, with CORDIC growth
    localparam int ANG_W  = 34;   // angle accumulator, 2^-30 rad
    localparam int SQ_W   = 31;   // integer square root result
    localparam int RAD_W  = 61;   // radicand, up to 2^60

    localparam logic signed [TERM_W-1:0] ONE_Q30     = TERM_W'(64'sd1073741824);
    localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = ANG_W'(64'sd1686629713);
    localparam logic signed [15:0]       PI_Q13      = 16'sd25736;
    localparam logic signed [14:0]       HALF_PI_Q13 = 15'sd12868;

    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [ANG_W-1:0]  t_angle;

    typedef struct packed {
        t_term sr;
        t_term cr;
        t_term sp;
        logic  clamped;
    } t_side;

    // atan(2^-i) in 2^-30 rad, rounded to nearest
    function automatic t_angle atan_entry(input logic [4:0] idx);
        t_angle v;
        case (idx)
            5'd0:  v = ANG_W'(64'd843314857);
            5'd1:  v = ANG_W'(64'd497837829);
            5'd2:  v = ANG_W'(64'd263043837);
            5'd3:  v = ANG_W'(64'd133525159);
            5'd4:  v = ANG_W'(64'd67021687);
            5'd5:  v = ANG_W'(64'd33543516);
            5'd6:  v = ANG_W'(64'd16775851);
            5'd7:  v = ANG_W'(64'd8388437);
            5'd8:  v = ANG_W'(64'd4194283);
            5'd9:  v = ANG_W'(64'd2097149);
            5'd31: v = '0;
            default: v = ANG_W'(64'd1) << (5'd30 - idx);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/qrp_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in 2^-30 rad, quadrant pre-rotation
// stage followed by CORDIC_N rotation stages. Uses qrp_pkg.
`default_nettype none

module qrp_cordic
    import qrp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_en,
    input  wire t_term  i_y,
    input  wire t_term  i_x,
    output t_angle      o_angle
);

    t_term  r_x    [0:CORDIC_N];
    t_term  r_y    [0:CORDIC_N];
    t_angle r_z    [0:CORDIC_N];
    logic   r_zero [0:CORDIC_N];

    // left half-plane is rotated by +-pi/2 first
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x[0] <= i_y;
                    r_y[0] <= -i_x;
                    r_z[0] <= HALF_PI_Q30;
                end else begin
                    r_x[0] <= -i_y;
                    r_y[0] <= i_x;
                    r_z[0] <= -HALF_PI_Q30;
                end
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_entry(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_entry(5'(i));
                end
            end
        end
    end

    assign o_angle = r_zero[CORDIC_N] ? '0 : r_z[CORDIC_N];

endmodule

`default_nettype wire

>>> sv/quaternion_to_roll_pitch_unit.sv
// Quaternion to roll/pitch top level: products, terms, pitch square root
// pipeline, two CORDIC pipelines and output stage. Uses qrp_pkg, qrp_cordic.
//
//  channel | valid         | ready          | payload
//  --------+---------------+----------------+-----------------------------------
//  input   | i_quat_valid  | o_quat_ready   | i_quat_x/y/z/w (Q1.15)
//  output  | o_angle_valid | i_angle_ready  | o_roll_angle, o_pitch_angle, o_pitch_clamped
//
// One transaction per cycle while the output is not stalled; the pipeline depth is
// set by the 31-stage bit-per-stage square root and the CORDIC rotation stages.
// The whole pipeline advances together whenever the output register is empty or
// being taken. Synchronous active-low reset clears the valid bits only.
`default_nettype none

module quaternion_to_roll_pitch_unit
    import qrp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_quat_valid,
    output logic                    o_quat_ready,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    output logic                    o_angle_valid,
    input  wire logic               i_angle_ready,
    output logic signed [15:0]      o_roll_angle,
    output logic signed [14:0]      o_pitch_angle,
    output logic                    o_pitch_clamped
);

    logic en;
    assign en           = !o_angle_valid || i_angle_ready;
    assign o_quat_ready = en;

    // stage 1: products
    logic r1_v;
    logic signed [PROD_W-1:0] r1_wx, r1_yz, r1_xx, r1_yy, r1_wy, r1_zx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_quat_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_wx <= i_quat_w * i_quat_x;
            r1_yz <= i_quat_y * i_quat_z;
            r1_xx <= i_quat_x * i_quat_x;
            r1_yy <= i_quat_y * i_quat_y;
            r1_wy <= i_quat_w * i_quat_y;
            r1_zx <= i_quat_z * i_quat_x;
        end
    end

    // stage 2: terms at 2^-30
    logic  r2_v;
    t_term r2_sr, r2_cr, r2_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sr <= (TERM_W'(r1_wx) + TERM_W'(r1_yz)) <<< 1;
            r2_cr <= ONE_Q30 - ((TERM_W'(r1_xx) + TERM_W'(r1_yy)) <<< 1);
            r2_sp <= (TERM_W'(r1_wy) - TERM_W'(r1_zx)) <<< 1;
        end
    end

    // stage 3: saturation check and s^2
    logic                 r3_v;
    t_side                r3_sd;
    logic [2*(SQ_W-1)-1:0] r3_sq;
    logic                 n3_clamped;
    t_term                n3_abs;
    logic [SQ_W-2:0]      n3_s;

    always_comb begin
        n3_clamped = (r2_sp >= ONE_Q30) || (r2_sp <= -ONE_Q30);
        n3_abs     = (r2_sp < 0) ? -r2_sp : r2_sp;
        n3_s       = n3_clamped ? '0 : n3_abs[SQ_W-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sd <= '{sr: r2_sr, cr: r2_cr, sp: r2_sp, clamped: n3_clamped};
            r3_sq <= n3_s * n3_s;
        end
    end

    // stage 4 and square root stages: index 0 holds 1 - s^2
    logic [RAD_W-1:0] r_rem [0:SQ_W];
    logic [SQ_W-1:0]  r_q   [0:SQ_W];
    t_side            r_sd  [0:SQ_W];
    logic             r_sv  [0:SQ_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= (RAD_W'(1) << (RAD_W - 1)) - RAD_W'(r3_sq);
            r_q[0]   <= '0;
            r_sd[0]  <= r3_sd;
        end
    end

    // stage j settles result bit SQ_W-j: try (q + 2^k)^2 against the remainder
    for (genvar j = 1; j <= SQ_W; j++) begin : g_sqrt
        localparam int K = SQ_W - j;
        logic [RAD_W:0] trial;
        assign trial = ({(RAD_W + 1 - SQ_W)'(0), r_q[j-1]} << (K + 1))
                     | ((RAD_W + 1)'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j] <= 1'b0;
            end else if (en) begin
                r_sv[j] <= r_sv[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sd[j] <= r_sd[j-1];
                if ({1'b0, r_rem[j-1]} >= trial) begin
                    r_rem[j] <= r_rem[j-1] - trial[RAD_W-1:0];
                    r_q[j]   <= r_q[j-1] | (SQ_W'(1) << K);
                end else begin
                    r_rem[j] <= r_rem[j-1];
                    r_q[j]   <= r_q[j-1];
                end
            end
        end
    end

    // CORDIC pipelines with sideband delay line
    t_side  sq_sd;
    t_angle roll_z, pitch_z;
    logic   r_cv      [0:CORDIC_N];
    logic   r_cclamp  [0:CORDIC_N];
    logic   r_cneg    [0:CORDIC_N];

    assign sq_sd = r_sd[SQ_W];

    qrp_cordic u_roll_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (sq_sd.sr),
        .i_x     (sq_sd.cr),
        .o_angle (roll_z)
    );

    qrp_cordic u_pitch_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (sq_sd.sp),
        .i_x     (TERM_W'(r_q[SQ_W])),
        .o_angle (pitch_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_sv[SQ_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cclamp[0] <= sq_sd.clamped;
            r_cneg[0]   <= sq_sd.sp[TERM_W-1];
        end
    end

    for (genvar i = 1; i <= CORDIC_N; i++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i] <= 1'b0;
            end else if (en) begin
                r_cv[i] <= r_cv[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cclamp[i] <= r_cclamp[i-1];
                r_cneg[i]   <= r_cneg[i-1];
            end
        end
    end

    // output stage: round half up to Q3.13 and limit
    logic signed [ANG_W:0]    roll_rnd, pitch_rnd;
    logic signed [ANG_W-17:0] roll_sh, pitch_sh;
    logic signed [15:0]       n_roll;
    logic signed [14:0]       n_pitch;

    always_comb begin
        roll_rnd  = (ANG_W + 1)'(roll_z) + (ANG_W + 1)'(65536);
        pitch_rnd = (ANG_W + 1)'(pitch_z) + (ANG_W + 1)'(65536);
        roll_sh   = roll_rnd[ANG_W:17];
        pitch_sh  = pitch_rnd[ANG_W:17];

        if (roll_sh > (ANG_W - 16)'(PI_Q13)) begin
            n_roll = PI_Q13;
        end else if (roll_sh < -(ANG_W - 16)'(PI_Q13)) begin
            n_roll = -PI_Q13;
        end else begin
            n_roll = roll_sh[15:0];
        end

        if (r_cclamp[CORDIC_N]) begin
            n_pitch = r_cneg[CORDIC_N] ? -HALF_PI_Q13 : HALF_PI_Q13;
        end else if (pitch_sh > (ANG_W - 16)'(HALF_PI_Q13)) begin
            n_pitch = HALF_PI_Q13;
        end else if (pitch_sh < -(ANG_W - 16)'(HALF_PI_Q13)) begin
            n_pitch = -HALF_PI_Q13;
        end else begin
            n_pitch = pitch_sh[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_angle_valid <= 1'b0;
        end else if (en) begin
            o_angle_valid <= r_cv[CORDIC_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_roll_angle    <= n_roll;
            o_pitch_angle   <= n_pitch;
            o_pitch_clamped <= r_cclamp[CORDIC_N];
        end
    end

    a_clamp_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle_valid && o_pitch_clamped |->
            (o_pitch_angle == HALF_PI_Q13) || (o_pitch_angle == -HALF_PI_Q13))
        else $error("clamped pitch is not +-pi/2");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle_valid |-> (o_roll_angle <= PI_Q13) && (o_roll_angle >= -PI_Q13))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle_valid |-> (o_pitch_angle <= HALF_PI_Q13) && (o_pitch_angle >= -HALF_PI_Q13))
        else $error("pitch out of range");

endmodule

`default_nettype wire
